// ===== rtl/mas_pkg.sv =====
// ----------------------------------------------------------------------------
// mas_pkg
// Shared sizes, codes and sequencer states for the middle access stack.
// ----------------------------------------------------------------------------
package mas_pkg;

  // pool size and derived widths
  localparam int DEPTH = 64;
  localparam int DW    = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  // action codes
  typedef enum logic [1:0] {
    ACT_PUSH     = 2'd0,
    ACT_POP      = 2'd1,
    ACT_READ_MID = 2'd2,
    ACT_DEL_MID  = 2'd3
  } action_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // sequencer steps
  typedef enum logic [2:0] {
    S_IDLE,
    S_A,
    S_B,
    S_C,
    S_D
  } state_t;

endpackage

// ===== rtl/middle_access_stack_unit.sv =====
// a transaction accepted while idle runs through the four sequencer steps S_A to S_D, which
//   share one read and one write port on each of the value and link memories; busy stays
//   high until the result strobe is registered, so transactions never overlap
// reset: synchronous active-low rst_n empties the stack; memories are not cleared
// the result is shown for one cycle on out_valid and cannot be stalled
// ----------------------------------------------------------------------------
// middle_access_stack_unit
// Bounded stack kept as a doubly linked list in a slot pool, with a pointer
// to the middle element; push, pop, read middle and delete middle.
// ----------------------------------------------------------------------------
module middle_access_stack_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_action,
  input  logic signed [31:0] in_push_value,
  output logic               out_valid,
  output logic signed [31:0] out_result_value,
  output logic [1:0]         out_status,
  output logic [6:0]         out_depth_now
);

  localparam int AW = mas_pkg::AW;
  localparam int CW = mas_pkg::CW;
  localparam int DW = mas_pkg::DW;

  // sequencer and transaction registers
  mas_pkg::state_t  state_r, state_nxt;
  mas_pkg::action_t act_r, act_nxt;
  mas_pkg::status_t status_r, status_nxt;
  logic [DW-1:0]    pval_r, pval_nxt;
  logic [DW-1:0]    val_r, val_nxt;
  logic [AW-1:0]    slot_r, slot_nxt;

  // stack bookkeeping
  logic [AW-1:0]    top_r, top_nxt;
  logic [AW-1:0]    mid_r, mid_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    fresh_r, fresh_nxt;
  logic [AW-1:0]    fhead_r, fhead_nxt;
  logic [CW-1:0]    fcnt_r, fcnt_nxt;

  // result registers
  logic             out_valid_r, out_valid_nxt;
  logic [DW-1:0]    res_val_r, res_val_nxt;
  logic [1:0]       res_st_r, res_st_nxt;
  logic [6:0]       res_dep_r, res_dep_nxt;

  // memory ports
  logic [DW-1:0] val_mem [mas_pkg::DEPTH];
  logic [AW-1:0] lt_mem  [mas_pkg::DEPTH];
  logic [AW-1:0] lb_mem  [mas_pkg::DEPTH];

  logic          val_we, lt_we, lb_we;
  logic [AW-1:0] val_wa, lt_wa, lb_wa;
  logic [DW-1:0] val_wd;
  logic [AW-1:0] lt_wd, lb_wd;
  logic [AW-1:0] val_ra, lt_ra, lb_ra;
  logic [DW-1:0] val_rd;
  logic [AW-1:0] lt_rd, lb_rd;

  logic          ok;

  // slot value memory
  always_ff @(posedge clk) begin
    if (val_we) begin
      val_mem[val_wa] <= val_wd;
    end
    val_rd <= val_mem[val_ra];
  end

  // toward-top link memory
  always_ff @(posedge clk) begin
    if (lt_we) begin
      lt_mem[lt_wa] <= lt_wd;
    end
    lt_rd <= lt_mem[lt_ra];
  end

  // toward-bottom link memory, also chains the free list
  always_ff @(posedge clk) begin
    if (lb_we) begin
      lb_mem[lb_wa] <= lb_wd;
    end
    lb_rd <= lb_mem[lb_ra];
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mas_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r       <= '0;
      mid_r       <= '0;
      cnt_r       <= '0;
      fresh_r     <= '0;
      fhead_r     <= '0;
      fcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      top_r       <= top_nxt;
      mid_r       <= mid_nxt;
      cnt_r       <= cnt_nxt;
      fresh_r     <= fresh_nxt;
      fhead_r     <= fhead_nxt;
      fcnt_r      <= fcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    status_r  <= status_nxt;
    pval_r    <= pval_nxt;
    val_r     <= val_nxt;
    slot_r    <= slot_nxt;
    res_val_r <= res_val_nxt;
    res_st_r  <= res_st_nxt;
    res_dep_r <= res_dep_nxt;
  end

  assign ok = (status_r == mas_pkg::ST_OK);

  // sequencer: next state, bookkeeping and memory control
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    status_nxt    = status_r;
    pval_nxt      = pval_r;
    val_nxt       = val_r;
    slot_nxt      = slot_r;
    top_nxt       = top_r;
    mid_nxt       = mid_r;
    cnt_nxt       = cnt_r;
    fresh_nxt     = fresh_r;
    fhead_nxt     = fhead_r;
    fcnt_nxt      = fcnt_r;
    out_valid_nxt = 1'b0;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    res_dep_nxt   = res_dep_r;
    val_we = 1'b0;
    val_wa = '0;
    val_wd = '0;
    val_ra = '0;
    lt_we  = 1'b0;
    lt_wa  = '0;
    lt_wd  = '0;
    lt_ra  = '0;
    lb_we  = 1'b0;
    lb_wa  = '0;
    lb_wd  = '0;
    lb_ra  = '0;

    case (state_r)
      // take a transaction and decide empty or full up front
      mas_pkg::S_IDLE: begin
        if (start) begin
          act_nxt  = mas_pkg::action_t'(in_action);
          pval_nxt = DW'(in_push_value);
          val_nxt  = '0;
          if (mas_pkg::action_t'(in_action) == mas_pkg::ACT_PUSH) begin
            status_nxt = (cnt_r == CW'(mas_pkg::DEPTH)) ? mas_pkg::ST_FULL : mas_pkg::ST_OK;
          end else begin
            status_nxt = (cnt_r == '0) ? mas_pkg::ST_EMPTY : mas_pkg::ST_OK;
          end
          state_nxt = mas_pkg::S_A;
        end
      end

      // pick the slot, write a pushed value and issue the first reads
      mas_pkg::S_A: begin
        if (ok) begin
          case (act_r)
            mas_pkg::ACT_PUSH: begin
              slot_nxt = (fcnt_r != '0) ? fhead_r : fresh_r[AW-1:0];
              val_we   = 1'b1;
              val_wa   = slot_nxt;
              val_wd   = pval_r;
              lt_we    = 1'b1;
              lt_wa    = slot_nxt;
              lt_wd    = '0;
              lb_ra    = fhead_r;
            end
            mas_pkg::ACT_POP: begin
              slot_nxt = top_r;
              val_ra   = top_r;
              lb_ra    = top_r;
            end
            mas_pkg::ACT_READ_MID: begin
              val_ra = mid_r;
            end
            mas_pkg::ACT_DEL_MID: begin
              slot_nxt = mid_r;
              val_ra   = mid_r;
              lt_ra    = mid_r;
              lb_ra    = mid_r;
            end
            default: begin
            end
          endcase
        end
        state_nxt = mas_pkg::S_B;
      end

      // capture read data, relink around the slot and update top, middle and count
      mas_pkg::S_B: begin
        if (ok) begin
          case (act_r)
            mas_pkg::ACT_PUSH: begin
              if (fcnt_r != '0) begin
                fhead_nxt = lb_rd;
                fcnt_nxt  = fcnt_r - CW'(1);
              end else begin
                fresh_nxt = fresh_r + CW'(1);
              end
              lb_we = 1'b1;
              lb_wa = slot_r;
              lb_wd = (cnt_r == '0) ? '0 : top_r;
              if (cnt_r != '0) begin
                lt_we = 1'b1;
                lt_wa = top_r;
                lt_wd = slot_r;
              end else begin
                mid_nxt = slot_r;
              end
              top_nxt = slot_r;
              cnt_nxt = cnt_r + CW'(1);
            end
            mas_pkg::ACT_POP: begin
              val_nxt = val_rd;
              top_nxt = lb_rd;
              cnt_nxt = cnt_r - CW'(1);
              if (cnt_r != CW'(1)) begin
                lt_we = 1'b1;
                lt_wa = lb_rd;
                lt_wd = '0;
              end
              lb_ra = mid_r;
            end
            mas_pkg::ACT_READ_MID: begin
              val_nxt = val_rd;
            end
            mas_pkg::ACT_DEL_MID: begin
              val_nxt = val_rd;
              cnt_nxt = cnt_r - CW'(1);
              if (cnt_r == CW'(1)) begin
                top_nxt = '0;
                mid_nxt = '0;
              end else if (cnt_r == CW'(2)) begin
                // the middle is the top when two are stacked
                top_nxt = lb_rd;
                mid_nxt = lb_rd;
                lt_we   = 1'b1;
                lt_wa   = lb_rd;
                lt_wd   = '0;
              end else begin
                // odd count moves the middle up, even count moves it down
                mid_nxt = cnt_r[0] ? lt_rd : lb_rd;
                lb_we   = 1'b1;
                lb_wa   = lt_rd;
                lb_wd   = lb_rd;
                lt_we   = 1'b1;
                lt_wa   = lb_rd;
                lt_wd   = lt_rd;
              end
            end
            default: begin
            end
          endcase
        end
        state_nxt = mas_pkg::S_C;
      end

      // free the slot, move the middle down on a pop that leaves an odd count, or fetch the middle's upper neighbor
      mas_pkg::S_C: begin
        if (ok) begin
          case (act_r)
            mas_pkg::ACT_PUSH: begin
              lt_ra = mid_r;
            end
            mas_pkg::ACT_POP, mas_pkg::ACT_DEL_MID: begin
              if (act_r == mas_pkg::ACT_POP && cnt_r[0]) begin
                mid_nxt = lb_rd;
              end
              lb_we     = 1'b1;
              lb_wa     = slot_r;
              lb_wd     = fhead_r;
              fhead_nxt = slot_r;
              fcnt_nxt  = fcnt_r + CW'(1);
            end
            default: begin
            end
          endcase
        end
        state_nxt = mas_pkg::S_D;
      end

      // final middle move on push and result out
      mas_pkg::S_D: begin
        if (ok && act_r == mas_pkg::ACT_PUSH && !cnt_r[0]) begin
          mid_nxt = lt_rd;
        end
        out_valid_nxt = 1'b1;
        res_val_nxt   = val_r;
        res_st_nxt    = status_r;
        res_dep_nxt   = 7'(cnt_r);
        state_nxt     = mas_pkg::S_IDLE;
      end

      default: begin
        state_nxt = mas_pkg::S_IDLE;
      end
    endcase
  end

  // ports
  assign busy             = (state_r != mas_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = signed'(res_val_r);
  assign out_status       = res_st_r;
  assign out_depth_now    = res_dep_r;

endmodule

// ===== rtl/mas_checker.sv =====
// ----------------------------------------------------------------------------
// mas_checker
// Port-level checks on the middle access stack, bound to the top level.
// ----------------------------------------------------------------------------
module mas_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [31:0] out_result_value,
  input logic [1:0]         out_status,
  input logic [6:0]         out_depth_now
);

  // every accepted transaction gives its result strobe
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##5 out_valid)
    else $error("result strobe missing after accepted transaction");

  // block is busy right after accepting
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // errors carry zero data
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != mas_pkg::ST_OK |-> out_result_value == 0)
    else $error("error result with nonzero data");

  // full only at full depth, empty only at zero depth
  a_full_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mas_pkg::ST_FULL |-> out_depth_now == 7'(mas_pkg::DEPTH))
    else $error("full status at wrong depth");

  a_empty_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mas_pkg::ST_EMPTY |-> out_depth_now == 7'd0)
    else $error("empty status at nonzero depth");

endmodule

bind middle_access_stack_unit mas_checker u_mas_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_result_value (out_result_value),
  .out_status       (out_status),
  .out_depth_now    (out_depth_now)
);
